>>> sv/adam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_pkg: shared types and constants of the Adam update engine
// Field widths, register indexes, sequencer states and the control bundles
// between the sequencer and the shared divide / root unit.
// ----------------------------------------------------------------------------
package adam_pkg;

   // item and store widths
   localparam int IDX_W   = 12;
   localparam int WORD_W  = 32;
   localparam int R_W     = 48;
   localparam int G2_W    = 47;
   localparam int POW_W   = 33;
   localparam int LR_W    = 24;
   localparam int DEC_W   = 16;
   localparam int EPS_W   = 16;
   localparam int Q_W     = 41;
   localparam int D_W     = 41;
   localparam int REQ_DATA_W = 80;

   // shared multiplier
   localparam int MUL_A_W = 50;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

   // divide / root unit
   localparam int ITER_IN_W  = 96;
   localparam int ITER_REM_W = 44;
   localparam int ITER_Q_W   = 64;
   localparam int ITER_CNT_W = 7;

   // iteration steps (operand bits taken from the top of the shift register down)
   localparam logic [ITER_CNT_W-1:0] STEPS_VHAT  = 7'd64;
   localparam logic [ITER_CNT_W-1:0] STEPS_RHAT  = 7'd80;
   localparam logic [ITER_CNT_W-1:0] STEPS_ROOT  = 7'd40;
   localparam logic [ITER_CNT_W-1:0] STEPS_RATIO = 7'd88;

   localparam logic [Q_W-1:0] RATIO_CAP = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [POW_W-1:0] POW_ONE = {1'b1, {(POW_W-1){1'b0}}};

   // defaults
   localparam int DEF_WEIGHT_DEPTH = 4096;
   localparam int DEF_BIAS_DEPTH   = 64;
   localparam logic [LR_W-1:0]  LR_RESET  = 24'd16777;
   localparam logic [DEC_W-1:0] MU_RESET  = 16'd58982;
   localparam logic [DEC_W-1:0] RHO_RESET = 16'd65470;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd2;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DECAY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_DECAY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON       = 2'd3;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_READ,
      S_MUL_V, S_MUL_G, S_MUL_SQH, S_MUL_SQL, S_MUL_R, S_MUL_G2,
      S_MUL_PM, S_MUL_PR,
      S_DV_GO, S_DV_WAIT, S_DR_GO, S_DR_WAIT,
      S_SQ_GO, S_SQ_WAIT, S_DQ_GO, S_DQ_WAIT,
      S_MUL_STEP, S_FINISH
   } state_type;

   typedef struct packed {
      logic                  start;
      logic                  root_mode;
      logic [ITER_CNT_W-1:0] steps;
   } iter_cmd_type;

   typedef struct packed {
      logic done;
      logic over;
   } iter_status_type;

endpackage

>>> sv/adam_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_iter: bit-serial restoring divider and square root
// One quotient or root bit per cycle. The operand arrives left-aligned in a
// 96-bit shift register; divide takes one bit a step, root takes two.
// ----------------------------------------------------------------------------
module adam_iter
   import adam_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  iter_cmd_type           cmd,
   input  logic [ITER_IN_W-1:0]   operand,
   input  logic [D_W-1:0]         divisor,
   output logic [ITER_Q_W-1:0]    result,
   output iter_status_type        status
);

   logic [ITER_IN_W-1:0]  shift_ff, shift_in;
   logic [ITER_REM_W-1:0] rem_ff, rem_in;
   logic [ITER_Q_W-1:0]   q_ff, q_in;
   logic [ITER_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  root_ff, root_in;
   logic                  over_ff, over_in;
   logic                  done_ff, done_in;
   logic [D_W-1:0]        div_ff, div_in;

   logic [ITER_REM_W-1:0] rem_sh;
   logic [ITER_REM_W-1:0] trial;
   logic                  take;

   // one step of the shared subtract and compare
   always_comb begin
      if (root_ff) begin
         rem_sh = {rem_ff[ITER_REM_W-3:0], shift_ff[ITER_IN_W-1 -: 2]};
         trial  = {q_ff[ITER_REM_W-3:0], 2'b01};
      end else begin
         rem_sh = {rem_ff[ITER_REM_W-2:0], shift_ff[ITER_IN_W-1]};
         trial  = ITER_REM_W'(div_ff);
      end
      take = (rem_sh >= trial);
   end

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      root_in  = root_ff;
      over_in  = over_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         shift_in = operand;
         rem_in   = '0;
         q_in     = '0;
         cnt_in   = cmd.steps;
         busy_in  = 1'b1;
         root_in  = cmd.root_mode;
         over_in  = 1'b0;
         div_in   = divisor;
      end else if (busy_ff) begin
         shift_in = root_ff ? {shift_ff[ITER_IN_W-3:0], 2'b00}
                            : {shift_ff[ITER_IN_W-2:0], 1'b0};
         rem_in   = take ? rem_sh - trial : rem_sh;
         q_in     = {q_ff[ITER_Q_W-2:0], take};
         // sticky flag: quotient has passed the ratio cap
         if ({q_ff[ITER_Q_W-2:0], take} > ITER_Q_W'(RATIO_CAP)) begin
            over_in = 1'b1;
         end
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == ITER_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      root_ff  <= root_in;
      over_ff  <= over_in;
      div_ff   <= div_in;
   end

   assign result      = q_ff;
   assign status.done = done_ff;
   assign status.over = over_ff;

endmodule

>>> sv/adam_optimizer_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_optimizer_update: Adam parameter update engine
// Per element: moment update, bias corrections, root, ratio and step, with
// one shared multiplier and one bit-serial divide / root unit in sequence.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     tdata index,weight,gradient;
//                                            tuser kind; tlast last_of_step
//  rsp      out        rsp_tvalid/tready     tdata new_weight; tlast step_done
//  csr      in         csr_we                csr_index, csr_wdata
//
//  An item is accepted only in S_IDLE, so the next item waits until the
//  result of the last one is loaded; the bit-serial divide / root unit and
//  its four operations set the pace. After reset a clearing pass over
//  max(WEIGHT_DEPTH, BIAS_DEPTH) addresses zeroes the moment memories;
//  req_tready stays low meanwhile.
//  A waiting result does not block the next accept; a new result waits for
//  the previous one to be taken.
// ----------------------------------------------------------------------------
module adam_optimizer_update
   import adam_pkg::*;
#(
   parameter int WEIGHT_DEPTH = DEF_WEIGHT_DEPTH,
   parameter int BIAS_DEPTH   = DEF_BIAS_DEPTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   // index [11:0], weight [43:12], gradient [75:44], zero [79:76]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // new_weight [31:0]
   output logic [WORD_W-1:0]      rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [LR_W-1:0]        csr_wdata
);

   localparam int WAW  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
   localparam int BAW  = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
   localparam int EXW0 = (WAW > IDX_W) ? WAW : IDX_W;
   localparam int EXW  = (EXW0 > BAW) ? EXW0 : BAW;
   localparam int MAXD = (WEIGHT_DEPTH > BIAS_DEPTH) ? WEIGHT_DEPTH : BIAS_DEPTH;
   localparam int CLW  = $clog2(MAXD + 1);
   localparam int ENT_W = R_W + WORD_W;

   // configuration and running powers
   logic [LR_W-1:0]  lr_ff;
   logic [DEC_W-1:0] mu_ff, rho_ff;
   logic [EPS_W-1:0] eps_ff;
   logic [POW_W-1:0] pow_m_ff, pow_r_ff;

   state_type state_ff, state_in;
   logic [CLW-1:0] clr_ff;

   // captured item
   logic              kind_ff, last_ff, inrange_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic signed [WORD_W-1:0] w_ff, g_ff;

   // datapath
   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic signed [PROD_W-1:0]  prod_ff, acc_ff;
   logic signed [PROD_W-1:0]  sum;
   logic [WORD_W-1:0]  v_ff, vmag_ff, gmag;
   logic [G2_W-1:0]    g2_ff;
   logic [R_W-1:0]     r_ff;
   logic [WORD_W-1:0]  pm_ff, pr_ff;
   logic [ITER_Q_W-1:0] vhat_ff, rhat_ff;
   logic [D_W-1:0]     d_ff;
   logic [Q_W-1:0]     q_ff;
   logic [WORD_W-1:0]  rsp_data_ff;
   logic               rsp_last_ff, rsp_valid_ff;

   // memories
   logic [ENT_W-1:0] wmem [WEIGHT_DEPTH];
   logic [ENT_W-1:0] bmem [BIAS_DEPTH];
   logic [ENT_W-1:0] wrd_ff, brd_ff;
   logic [EXW-1:0]   idx_ext;
   logic [WAW-1:0]   waddr;
   logic [BAW-1:0]   baddr;
   logic             wwe, bwe, clearing;
   logic [ENT_W-1:0] wdata;
   logic [CLW-1:0]   clr_last;

   // shared divide / root unit
   iter_cmd_type          icmd;
   iter_status_type       istat;
   logic [ITER_IN_W-1:0]  iop;
   logic [D_W-1:0]        idiv;
   logic [ITER_Q_W-1:0]   ires;

   adam_iter u_iter (
      .clock   (clock),
      .reset   (reset),
      .cmd     (icmd),
      .operand (iop),
      .divisor (idiv),
      .result  (ires),
      .status  (istat)
   );

   assign idx_ext  = EXW'(idx_ff);
   assign clearing = (state_ff == S_CLEAR);
   assign clr_last = CLW'(MAXD - 1);
   assign sum      = acc_ff + prod_ff;
   assign gmag     = g_ff[WORD_W-1] ? WORD_W'(-g_ff) : WORD_W'(g_ff);
   assign wdata    = clearing ? '0 : {r_ff, v_ff};

   // memory write select: clearing sweep, else write-back of moments
   always_comb begin
      if (clearing) begin
         waddr = WAW'(clr_ff);
         baddr = BAW'(clr_ff);
         wwe   = (32'(clr_ff) < WEIGHT_DEPTH);
         bwe   = (32'(clr_ff) < BIAS_DEPTH);
      end else begin
         waddr = idx_ext[WAW-1:0];
         baddr = idx_ext[BAW-1:0];
         wwe   = (state_ff == S_MUL_PR) && inrange_ff && !kind_ff;
         bwe   = (state_ff == S_MUL_PR) && inrange_ff && kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wwe) begin
         wmem[waddr] <= wdata;
      end
      wrd_ff <= wmem[idx_ext[WAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (bwe) begin
         bmem[baddr] <= wdata;
      end
      brd_ff <= bmem[idx_ext[BAW-1:0]];
   end

   // sequencer: next state, multiplier operands, unit commands
   always_comb begin
      state_in   = state_ff;
      mul_a      = '0;
      mul_b      = '0;
      icmd       = '0;
      iop        = '0;
      idiv       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) state_in = S_READ;
         end
         S_READ:    state_in = S_MUL_V;
         S_MUL_V: begin
            mul_a = inrange_ff ? MUL_A_W'($signed(kind_ff ? brd_ff[WORD_W-1:0]
                                                         : wrd_ff[WORD_W-1:0]))
                               : '0;
            mul_b = MUL_B_W'(mu_ff);
            state_in = S_MUL_G;
         end
         S_MUL_G: begin
            mul_a = MUL_A_W'(g_ff);
            mul_b = MUL_B_W'(17'h10000 - {1'b0, mu_ff});
            state_in = S_MUL_SQH;
         end
         S_MUL_SQH: begin
            mul_a = MUL_A_W'(gmag);
            mul_b = MUL_B_W'(gmag[WORD_W-1:16]);
            state_in = S_MUL_SQL;
         end
         S_MUL_SQL: begin
            mul_a = MUL_A_W'(gmag);
            mul_b = MUL_B_W'(gmag[15:0]);
            state_in = S_MUL_R;
         end
         S_MUL_R: begin
            mul_a = inrange_ff ? MUL_A_W'(kind_ff ? brd_ff[ENT_W-1:WORD_W]
                                                  : wrd_ff[ENT_W-1:WORD_W])
                               : '0;
            mul_b = MUL_B_W'(rho_ff);
            state_in = S_MUL_G2;
         end
         S_MUL_G2: begin
            mul_a = MUL_A_W'(g2_ff);
            mul_b = MUL_B_W'(17'h10000 - {1'b0, rho_ff});
            state_in = S_MUL_PM;
         end
         S_MUL_PM: begin
            mul_a = MUL_A_W'(pow_m_ff);
            mul_b = MUL_B_W'(mu_ff);
            state_in = S_MUL_PR;
         end
         S_MUL_PR: begin
            mul_a = MUL_A_W'(pow_r_ff);
            mul_b = MUL_B_W'(rho_ff);
            state_in = S_DV_GO;
         end
         S_DV_GO: begin
            icmd.start = 1'b1;
            icmd.steps = STEPS_VHAT;
            iop  = {vmag_ff, 64'b0};
            idiv = D_W'(POW_ONE - {1'b0, pm_ff});
            state_in = S_DV_WAIT;
         end
         S_DV_WAIT: begin
            if (istat.done) state_in = S_DR_GO;
         end
         S_DR_GO: begin
            icmd.start = 1'b1;
            icmd.steps = STEPS_RHAT;
            iop  = {r_ff, 48'b0};
            idiv = D_W'(POW_ONE - {1'b0, pr_ff});
            state_in = S_DR_WAIT;
         end
         S_DR_WAIT: begin
            if (istat.done) state_in = S_SQ_GO;
         end
         S_SQ_GO: begin
            icmd.start     = 1'b1;
            icmd.root_mode = 1'b1;
            icmd.steps     = STEPS_ROOT;
            iop  = {rhat_ff, 32'b0};
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (istat.done) state_in = S_DQ_GO;
         end
         S_DQ_GO: begin
            icmd.start = 1'b1;
            icmd.steps = STEPS_RATIO;
            iop  = {vhat_ff, 32'b0};
            idiv = d_ff;
            state_in = S_DQ_WAIT;
         end
         S_DQ_WAIT: begin
            if (istat.done) state_in = S_MUL_STEP;
         end
         S_MUL_STEP: begin
            mul_a = MUL_A_W'(q_ff);
            mul_b = lr_ff;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // keep the step product steady while the output slot is busy
            mul_a = MUL_A_W'(q_ff);
            mul_b = lr_ff;
            if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_ff <= clr_ff + 1'b1;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= LR_RESET;
         mu_ff  <= MU_RESET;
         rho_ff <= RHO_RESET;
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEARNING_RATE: lr_ff  <= csr_wdata;
            CSR_FIRST_DECAY:   mu_ff  <= csr_wdata[DEC_W-1:0];
            CSR_SECOND_DECAY:  rho_ff <= csr_wdata[DEC_W-1:0];
            CSR_EPSILON:       eps_ff <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // shared multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * $signed({1'b0, mul_b});
   end

   // datapath registers, loaded by sequencer state
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            idx_ff  <= req_tdata[IDX_W-1:0];
            w_ff    <= req_tdata[IDX_W +: WORD_W];
            g_ff    <= req_tdata[IDX_W+WORD_W +: WORD_W];
            kind_ff <= req_tuser;
            last_ff <= req_tlast;
            inrange_ff <= req_tuser
               ? (32'(req_tdata[IDX_W-1:0]) < BIAS_DEPTH)
               : (32'(req_tdata[IDX_W-1:0]) < WEIGHT_DEPTH);
         end
         S_MUL_G: acc_ff <= prod_ff;
         S_MUL_SQH: begin
            // first moment, truncated toward zero
            if (sum[PROD_W-1]) v_ff <= -(WORD_W'((-sum) >>> 16));
            else               v_ff <= WORD_W'(sum >>> 16);
         end
         S_MUL_SQL: acc_ff <= prod_ff;
         S_MUL_R:   g2_ff <= G2_W'(acc_ff + (prod_ff >>> 16));
         S_MUL_G2: begin
            acc_ff  <= prod_ff;
            vmag_ff <= v_ff[WORD_W-1] ? -v_ff : v_ff;
         end
         S_MUL_PM:  r_ff <= sum[R_W+15:16];
         S_MUL_PR:  pm_ff <= prod_ff[WORD_W+15:16];
         S_DV_GO:   pr_ff <= prod_ff[WORD_W+15:16];
         S_DV_WAIT: if (istat.done) vhat_ff <= ires;
         S_DR_WAIT: if (istat.done) rhat_ff <= ires;
         S_SQ_WAIT: if (istat.done) d_ff <= D_W'(ires[39:0]) + D_W'(eps_ff);
         S_DQ_WAIT: begin
            if (istat.done) begin
               // zero divisor: cap unless there is nothing to divide
               if (d_ff == '0)      q_ff <= (vhat_ff == '0) ? '0 : RATIO_CAP;
               else if (istat.over) q_ff <= RATIO_CAP;
               else                 q_ff <= ires[Q_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // final step, saturation, output word and power advance
   logic signed [WORD_W+12:0] upd;
   always_comb begin
      upd = kind_ff ? '0 : '0;
      upd = v_ff[WORD_W-1]
            ? (WORD_W+13)'(w_ff) + $signed({2'b0, prod_ff[Q_W+23:24]})
            : (WORD_W+13)'(w_ff) - $signed({2'b0, prod_ff[Q_W+23:24]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pow_m_ff     <= POW_ONE;
         pow_r_ff     <= POW_ONE;
      end else begin
         if (state_ff == S_FINISH && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            if (last_ff) begin
               pow_m_ff <= {1'b0, pm_ff};
               pow_r_ff <= {1'b0, pr_ff};
            end
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && (!rsp_valid_ff || rsp_tready)) begin
         rsp_last_ff <= last_ff;
         if (upd > (WORD_W+13)'(32'sh7FFFFFFF))       rsp_data_ff <= 32'h7FFFFFFF;
         else if (upd < -(WORD_W+13)'(33'sh80000000)) rsp_data_ff <= 32'h80000000;
         else                                         rsp_data_ff <= upd[WORD_W-1:0];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> dv/tb_adam_optimizer_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adam_optimizer_update: self-checking bench for the Adam update engine
// Drives parameter words through the request stream under several register
// settings and idle patterns, predicts every updated weight with an
// independent fixed-point Adam model, and checks each response word in order.
// ----------------------------------------------------------------------------
module tb_adam_optimizer_update;
   import adam_pkg::*;

   localparam int WDEPTH    = DEF_WEIGHT_DEPTH;
   localparam int BDEPTH    = DEF_BIAS_DEPTH;
   localparam int STALL_MAX = 20000;
   localparam int HOLD_LEN  = 2500;

   typedef struct {
      logic        kind;
      logic [11:0] idx;
      logic [31:0] w;
      logic [31:0] g;
      logic        last;
   } param_word_type;

   typedef struct {
      logic [31:0] new_w;
      logic        done;
   } update_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WORD_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [LR_W-1:0]       csr_wdata = '0;

   adam_optimizer_update uut (.*);

   always #1 clock = ~clock;

   // predictor state
   int           m1_w [WDEPTH];
   logic [47:0]  m2_w [WDEPTH];
   int           m1_b [BDEPTH];
   logic [47:0]  m2_b [BDEPTH];
   logic [32:0]  pow_mu, pow_rho;
   logic [23:0]  lr_q;
   logic [15:0]  mu_q, rho_q, eps_q;

   param_word_type pending_words[$];
   update_type     expected_updates[$];
   param_word_type cur_word;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic         hold_go = 1'b0;
   logic         hold_done = 1'b0;
   int           hold_cnt = 0;
   int           errors = 0;
   int           quiet_cycles = 0;

   // floor(sqrt(x * 2^16))
   function automatic logic [63:0] root_q24(logic [63:0] x);
      logic [79:0]  rad;
      logic [127:0] root, rem, trial;
      rad = {x, 16'd0};
      root = 0;
      rem = 0;
      for (int i = 39; i >= 0; i--) begin
         rem = (rem << 2) | rad[2*i +: 2];
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   // advance the moments for one word and return the updated weight
   function automatic update_type adam_update(param_word_type p);
      update_type   u;
      logic         inr, neg;
      longint       v, g, acc, w;
      logic [127:0] r, g2, mag, pm, pr, vhat, rhat, root, d, q, s;
      inr = p.kind ? (p.idx < BDEPTH) : (p.idx < WDEPTH);
      v = 0;
      r = 0;
      if (inr) begin
         v = p.kind ? m1_b[p.idx] : m1_w[p.idx];
         r = p.kind ? m2_b[p.idx] : m2_w[p.idx];
      end
      g = longint'($signed(p.g));
      w = longint'($signed(p.w));
      acc = longint'(mu_q) * v + longint'(65536 - int'(mu_q)) * g;
      v = (acc < 0) ? -((-acc) >>> 16) : (acc >>> 16);
      mag = (g < 0) ? 128'(-g) : 128'(g);
      g2 = (mag * mag) >> 16;
      r = (128'(rho_q) * r + 128'(65536 - int'(rho_q)) * g2) >> 16;
      if (inr) begin
         if (p.kind) begin
            m1_b[p.idx] = int'(v);
            m2_b[p.idx] = r[47:0];
         end else begin
            m1_w[p.idx] = int'(v);
            m2_w[p.idx] = r[47:0];
         end
      end
      pm = (128'(pow_mu) * mu_q) >> 16;
      pr = (128'(pow_rho) * rho_q) >> 16;
      neg = v < 0;
      mag = neg ? 128'(-v) : 128'(v);
      vhat = (mag << 32) / ((128'(1) << 32) - pm);
      rhat = (r << 32) / ((128'(1) << 32) - pr);
      root = root_q24(rhat[63:0]);
      d = root + eps_q;
      if (d == 0) begin
         q = (vhat == 0) ? 0 : RATIO_CAP;
      end else begin
         q = (vhat[63:0] << 24) / d;
         if (q > RATIO_CAP) q = RATIO_CAP;
      end
      s = (128'(lr_q) * q) >> 24;
      acc = neg ? w + longint'(s) : w - longint'(s);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      if (p.last) begin
         pow_mu = pm[32:0];
         pow_rho = pr[32:0];
      end
      u.new_w = acc[31:0];
      u.done = p.last;
      return u;
   endfunction

   // request driver: predict on accept, then present the next word or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_updates.push_back(adam_update(cur_word));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_word <= pending_words[0];
               req_tdata <= {4'd0, pending_words[0].g, pending_words[0].w,
                             pending_words[0].idx};
               req_tuser <= pending_words[0].kind;
               req_tlast <= pending_words[0].last;
               req_tvalid <= 1'b1;
               void'(pending_words.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compare against the oldest prediction, then stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_updates.size() == 0) begin
            $display("%0t: unexpected word new_weight=%h step_done=%b", $time,
                     rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            if (rsp_tdata !== expected_updates[0].new_w) begin
               $display("%0t: new_weight expected %h actual %h", $time,
                        expected_updates[0].new_w, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== expected_updates[0].done) begin
               $display("%0t: step_done expected %b actual %b", $time,
                        expected_updates[0].done, rsp_tlast);
               errors++;
            end
            void'(expected_updates.pop_front());
         end
      end
      if (reset || (hold_go && !hold_done)) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off while the sender keeps offering words
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [LR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LEARNING_RATE: lr_q = val;
         CSR_FIRST_DECAY:   mu_q = val[15:0];
         CSR_SECOND_DECAY:  rho_q = val[15:0];
         CSR_EPSILON:       eps_q = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [23:0] lr, logic [15:0] mu, logic [15:0] rho,
                           logic [15:0] eps);
      write_reg(CSR_LEARNING_RATE, lr);
      write_reg(CSR_FIRST_DECAY, {8'd0, mu});
      write_reg(CSR_SECOND_DECAY, {8'd0, rho});
      write_reg(CSR_EPSILON, {8'd0, eps});
   endtask

   task automatic add_word(logic kind, logic [11:0] idx, logic [31:0] w,
                           logic [31:0] g, logic last);
      param_word_type p;
      p.kind = kind;
      p.idx = idx;
      p.w = w;
      p.g = g;
      p.last = last;
      pending_words.push_back(p);
   endtask

   // mostly revisited indexes so moments build up; some full-range noise
   task automatic add_random(int n);
      logic        kind;
      logic [11:0] idx;
      logic [31:0] w, g;
      for (int i = 0; i < n; i++) begin
         kind = ($urandom_range(3) == 0);
         case ($urandom_range(9))
            0:       idx = 12'($urandom);
            1:       idx = kind ? 12'($urandom_range(64, 127))
                                : 12'($urandom_range(4064, 4095));
            default: idx = 12'($urandom_range(15));
         endcase
         case ($urandom_range(5))
            0:       g = $urandom;
            1:       g = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       g = $urandom_range(3) - 1;
            default: g = {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
         endcase
         case ($urandom_range(5))
            0:       w = ($urandom_range(1)) ? 32'h7FFF_FFF0 : 32'h8000_0010;
            default: w = $urandom;
         endcase
         add_word(kind, idx, w, g, $urandom_range(7) == 0);
      end
   endtask

   // wait until every word is sent and every update has come back
   task automatic drain();
      while (pending_words.size() > 0 || req_tvalid || expected_updates.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   initial begin
      for (int i = 0; i < WDEPTH; i++) begin
         m1_w[i] = 0;
         m2_w[i] = '0;
      end
      for (int i = 0; i < BDEPTH; i++) begin
         m1_b[i] = 0;
         m2_b[i] = '0;
      end
      pow_mu = POW_ONE;
      pow_rho = POW_ONE;
      lr_q = LR_RESET;
      mu_q = MU_RESET;
      rho_q = RHO_RESET;
      eps_q = EPS_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // defaults: field extremes, both stores, out-of-range bias index
      set_idling(0, 0);
      add_word(1'b0, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      add_word(1'b0, 12'd4095, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_word(1'b0, 12'd1, 32'h0100_0000, 32'h0000_0000, 1'b0);
      add_word(1'b1, 12'd0, 32'h0000_0000, 32'hFF00_0000, 1'b0);
      add_word(1'b1, 12'd63, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
      add_word(1'b1, 12'd64, 32'h1234_5678, 32'h0123_4567, 1'b0);
      add_word(1'b1, 12'd4095, 32'h8765_4321, 32'hFEDC_BA98, 1'b1);
      add_word(1'b0, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      add_word(1'b0, 12'd4095, 32'h8000_0000, 32'h8000_0000, 1'b1);
      drain();

      // largest settings; push weights past both saturation limits
      set_regs(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_word(1'b0, 12'd2, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      add_word(1'b0, 12'd3, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      add_word(1'b1, 12'd5, 32'h7FFF_FF00, 32'hC000_0000, 1'b1);
      drain();

      // zero decays, zero epsilon: zero divisor with and without a ratio
      set_regs(24'd0, 16'd0, 16'd0, 16'd0);
      add_word(1'b0, 12'd7, 32'h0000_0100, 32'h0000_0001, 1'b0);
      add_word(1'b0, 12'd8, 32'h0000_0100, 32'h0000_0000, 1'b1);
      drain();
      set_regs(24'hFF_FFFF, 16'd0, 16'd0, 16'd0);
      add_word(1'b0, 12'd7, 32'h0000_0100, 32'hFFFF_FFFF, 1'b0);
      add_word(1'b1, 12'd9, 32'h8000_0000, 32'h0000_0000, 1'b1);
      drain();

      // random phases under changing settings and idle patterns
      set_regs(LR_RESET, MU_RESET, RHO_RESET, EPS_RESET);
      add_random(300);
      drain();

      set_idling(68, 0);
      set_regs(24'h10_0000, 16'd32768, 16'd60000, 16'd0);
      add_random(300);
      drain();

      set_idling(0, 68);
      set_regs(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_random(300);
      drain();

      // receiver holds off while requests keep coming
      set_idling(0, 0);
      set_regs(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(20)));
      add_random(300);
      hold_go <= 1'b1;
      drain();

      set_idling(32, 32);
      set_regs(24'($urandom_range(1 << 18)), 16'($urandom_range(50000, 65535)),
               16'($urandom_range(60000, 65535)), 16'($urandom_range(4)));
      add_random(325);
      drain();

      set_idling(0, 0);
      set_regs(24'd0, 16'd0, 16'd0, 16'd0);
      add_random(310);
      drain();

      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/adam_pkg.sv
sv/adam_iter.sv
sv/adam_optimizer_update.sv
dv/tb_adam_optimizer_update.sv
